// ----- src/etcd_pkg.sv -----
`default_nettype none
package etcd_pkg;

	localparam int OffW   = 18;
	localparam int DaysW  = 16;	// max day count 49710
	localparam int YearBase = 1970;
	localparam int YearCount = 138;	// 1970 .. 2107, one past the last reachable year
	localparam int TblDepth = 256;

	// days in year, Gregorian rule (elaboration only)
	function automatic logic [8:0] year_len(input logic [11:0] y);
		logic leap;
		leap = (y[1:0] == 2'd0) && ((y % 12'd100 != 12'd0) || (y % 12'd400 == 12'd0));
		year_len = leap ? 9'd366 : 9'd365;
	endfunction

	// leap year from year index; 2100 is the only century without a leap day in range
	function automatic logic leap_idx(input logic [7:0] i);
		leap_idx = (i[1:0] == 2'd2) && (i != 8'(2100 - YearBase));
	endfunction

	// days in month m (0 = January)
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd1:    r = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
			default: r = 5'd31;
		endcase
		month_len = r;
	endfunction

	// day of year on which month m starts (0 = January)
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] acc;
		acc = '0;
		for (int k = 0; k < 11; k++)
			if (4'(k) < m) acc = acc + 9'(month_len(4'(k), leap));
		month_start = acc;
	endfunction

	// day count of Jan 1 for each year index, all ones past the last year
	function automatic logic [TblDepth*DaysW-1:0] year_table();
		logic [TblDepth*DaysW-1:0] tbl;
		logic [DaysW-1:0] acc;
		acc = '0;
		for (int k = 0; k < TblDepth; k++) begin
			tbl[k*DaysW +: DaysW] = (k < YearCount) ? acc : {DaysW{1'b1}};
			if (k < YearCount) acc = acc + DaysW'(year_len(12'(YearBase + k)));
		end
		year_table = tbl;
	endfunction

	localparam logic [TblDepth*DaysW-1:0] YearStartTbl = year_table();

endpackage
`default_nettype wire

// ----- src/etcd_year_lut.sv -----
`default_nettype none
// Constant table: start day of each year since the base year
module etcd_year_lut
	import etcd_pkg::*;
(
	input  wire logic [7:0]       idx,
	output logic      [DaysW-1:0] start_day
);
	assign start_day = YearStartTbl[32'(idx) * DaysW +: DaysW];
endmodule
`default_nettype wire

// ----- src/epoch_to_calendar_date.sv -----
// Epoch seconds to calendar date converter.
// Slave stream s_axis_* takes one word per item: tdata[31:0] = unix_seconds.
// Master stream m_axis_* returns one word per item, tdata from bit 0 up:
//   second_of_minute[5:0], minute_of_hour[11:6], hour_of_day[16:12],
//   day_of_week[19:17], year_number[31:20], month_number[35:32],
//   day_of_month[40:36], zero fill to 48 bits.
// cfg_we/cfg_data write the signed 18-bit time_offset; write only when idle.
// Seven register stages: offset add, divide by 60, divide by 60, divide by
// 24, upper half of the year search plus weekday, lower half of the year
// search with day-of-year, then month lookup into the output register.
// A new word can enter every cycle while the receiver is not stalling, so one
// word per cycle is sustained. The divides are reciprocal multiplies.
// Reset clears all valid bits and the offset register to zero.
// When the receiver stalls, the whole pipeline holds; the input is ready only
// while the pipeline can advance, so nothing is lost or repeated.
`default_nettype none
module epoch_to_calendar_date
	import etcd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [OffW-1:0]  cfg_data,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [31:0]      s_axis_tdata,	// unix_seconds
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic      [47:0]      m_axis_tdata	// see head comment
);
	logic [OffW-1:0] off_q;
	logic v1, v2, v3, v4, v5, v6, v7;
	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = v7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) off_q <= '0;
		else if (cfg_we) off_q <= cfg_data;
	end

	// stage data
	logic [31:0] t_s1;
	logic [26:0] m_s2; logic [5:0] sec_s2;
	logic [20:0] h_s3; logic [5:0] sec_s3, min_s3;
	logic [15:0] d_s4; logic [4:0] hr_s4; logic [5:0] sec_s4, min_s4;
	logic [15:0] d_s5; logic [4:0] hr_s5; logic [5:0] sec_s5, min_s5; logic [2:0] wd_s5;
	logic [7:0] yi_s5; logic [DaysW-1:0] ys_s5;
	logic [8:0] doy_s6; logic [7:0] yi_s6; logic [4:0] hr_s6; logic [5:0] sec_s6, min_s6;
	logic [2:0] wd_s6;

	// divide helpers by reciprocal
	logic [26:0] q60a; logic [5:0] r60a;
	logic [20:0] q60b; logic [5:0] r60b;
	logic [15:0] q24;  logic [4:0] r24;
	logic [2:0]  r7;
	always_comb begin
		logic [63:0] p; logic [31:0] r;
		p = 64'(t_s1) * 64'd2290649225;	// ceil(2^37/60)
		q60a = 27'(p >> 37);
		r = t_s1 - 32'(q60a) * 32'd60;
		r60a = r[5:0];
	end
	always_comb begin
		logic [63:0] p; logic [26:0] r;
		p = 64'(m_s2) * 64'd2290649225;
		q60b = 21'(p >> 37);
		r = m_s2 - 27'(q60b) * 27'd60;
		r60b = r[5:0];
	end
	always_comb begin
		logic [47:0] p; logic [20:0] r;
		p = 48'(h_s3) * 48'd44739243;	// ceil(2^30/24)
		q24 = 16'(p >> 30);
		r = h_s3 - 21'(q24) * 21'd24;
		r24 = r[4:0];
	end

	// weekday from day count, epoch day was a Thursday
	always_comb begin
		logic [16:0] w; logic [35:0] pw; logic [16:0] q7;
		w = 17'(d_s4) + 17'd4;
		pw = 36'(w) * 36'd149797;	// ceil(2^20/7)
		q7 = 17'(pw >> 20);
		r7 = 3'(w - q7 * 17'd7);
	end

	// year index, upper four steps of the binary search
	logic [4:0][7:0]       yh;
	logic [4:0][DaysW-1:0] sh;
	logic [3:0][DaysW-1:0] lh;
	assign yh[0] = '0;
	assign sh[0] = '0;
	for (genvar g = 0; g < 4; g++) begin : g_hi
		etcd_year_lut u_lut (.idx(yh[g] | (8'd1 << (7 - g))), .start_day(lh[g]));
		assign yh[g+1] = (lh[g] <= d_s4) ? (yh[g] | (8'd1 << (7 - g))) : yh[g];
		assign sh[g+1] = (lh[g] <= d_s4) ? lh[g] : sh[g];
	end

	// year index, lower four steps
	logic [4:0][7:0]       yl;
	logic [4:0][DaysW-1:0] sl;
	logic [3:0][DaysW-1:0] ll;
	assign yl[0] = yi_s5;
	assign sl[0] = ys_s5;
	for (genvar g = 0; g < 4; g++) begin : g_lo
		etcd_year_lut u_lut (.idx(yl[g] | (8'd1 << (3 - g))), .start_day(ll[g]));
		assign yl[g+1] = (ll[g] <= d_s5) ? (yl[g] | (8'd1 << (3 - g))) : yl[g];
		assign sl[g+1] = (ll[g] <= d_s5) ? ll[g] : sl[g];
	end

	// month: parallel compares against month start days
	logic [3:0] mo; logic [8:0] dd;
	always_comb begin
		logic lp; logic [8:0] base;
		lp = leap_idx(yi_s6);
		mo = '0; base = '0;
		for (int m = 1; m < 12; m++)
			if (doy_s6 >= month_start(4'(m), lp)) begin
				mo = 4'(m);
				base = month_start(4'(m), lp);
			end
		dd = doy_s6 - base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v1, v2, v3, v4, v5, v6, v7} <= '0;
		end else if (adv) begin
			v1 <= s_axis_tvalid; v2 <= v1; v3 <= v2; v4 <= v3;
			v5 <= v4; v6 <= v5; v7 <= v6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= s_axis_tdata + {{(32-OffW){off_q[OffW-1]}}, off_q};
			m_s2 <= q60a; sec_s2 <= r60a;
			h_s3 <= q60b; min_s3 <= r60b; sec_s3 <= sec_s2;
			d_s4 <= q24; hr_s4 <= r24;
			sec_s4 <= sec_s3; min_s4 <= min_s3;
			d_s5 <= d_s4; yi_s5 <= yh[4]; ys_s5 <= sh[4]; hr_s5 <= hr_s4;
			wd_s5 <= r7 + 3'd1;
			sec_s5 <= sec_s4; min_s5 <= min_s4;
			doy_s6 <= 9'(d_s5 - sl[4]); yi_s6 <= yl[4]; hr_s6 <= hr_s5;
			wd_s6 <= wd_s5; sec_s6 <= sec_s5; min_s6 <= min_s5;
			m_axis_tdata <= {7'd0, 5'(dd + 9'd1), mo + 4'd1,
				12'(YearBase) + 12'(yi_s6), wd_s6, hr_s6, min_s6, sec_s6};
		end
	end
endmodule
`default_nettype wire

// ----- src/etcd_checker.sv -----
`default_nettype none
module etcd_checker
	import etcd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);
	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed under stall");
	// input blocked only under output stall
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input blocked without stall");
	// fields in range
	a_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[5:0] < 6'd60 && m_axis_tdata[11:6] < 6'd60
			&& m_axis_tdata[16:12] < 5'd24 && m_axis_tdata[19:17] != 3'd0
			&& m_axis_tdata[35:32] != 4'd0 && m_axis_tdata[35:32] < 4'd13)
		else $error("output field out of range");
endmodule
bind epoch_to_calendar_date etcd_checker u_chk (.*);
`default_nettype wire

// ----- tb/tb_epoch_to_calendar_date.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_epoch_to_calendar_date;
	import etcd_pkg::*;

	typedef struct packed {
		logic [4:0]  mday;
		logic [3:0]  month;
		logic [11:0] year;
		logic [2:0]  wday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cal_date_t;

	localparam int StallLimit = 20000;
	localparam int DrainCycles = 20;
	localparam int LongHold = 200;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [OffW-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;	// unix_seconds
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;	// second, minute, hour, weekday, year, month, mday, zero fill

	// local copy of the offset register
	logic [OffW-1:0] tz_offset;
	cal_date_t dates_due[$];
	int errors = 0;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_reqs = 0;
	int hold_taken = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	epoch_to_calendar_date DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit gregorian_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// convert local epoch seconds to a calendar date
	function automatic cal_date_t calendar_of(input logic [31:0] secs);
		cal_date_t d;
		int unsigned t, days, yr, mo, mlen;
		int unsigned mlens[12];
		mlens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		t = secs + {{(32-OffW){tz_offset[OffW-1]}}, tz_offset};
		d.second = 6'(t % 60);
		t = t / 60;
		d.minute = 6'(t % 60);
		t = t / 60;
		d.hour = 5'(t % 24);
		days = t / 24;
		d.wday = 3'((days + 4) % 7 + 1);
		yr = 1970;
		while (days >= (gregorian_leap(yr) ? 366 : 365)) begin
			days -= gregorian_leap(yr) ? 366 : 365;
			yr++;
		end
		for (mo = 0; mo < 11; mo++) begin
			mlen = (mo == 1) ? (gregorian_leap(yr) ? 29 : 28) : mlens[mo];
			if (days < mlen) break;
			days -= mlen;
		end
		d.year = 12'(yr);
		d.month = 4'(mo + 1);
		d.mday = 5'(days + 1);
		return d;
	endfunction

	// send one word, idling before it at the current rate
	task automatic send_seconds(input logic [31:0] secs);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= secs;
		do @(posedge clk); while (!s_axis_tready);
		dates_due.push_back(calendar_of(secs));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (dates_due.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_offset(input logic [OffW-1:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		tz_offset = val;
	endtask

	// random seconds, biased toward both ends of the range
	function automatic logic [31:0] rand_seconds();
		case ($urandom_range(3))
			0: return $urandom_range(200000);
			1: return 32'hFFFF_FFFF - $urandom_range(200000);
			default: return $urandom;
		endcase
	endfunction

	// edge values: epoch, wraps, leap days, century years
	task automatic test_directed_dates();
		write_offset('0);
		send_seconds(32'd0);
		send_seconds(32'hFFFF_FFFF);
		send_seconds(32'h5555_5555);
		send_seconds(32'hAAAA_AAAA);
		send_seconds(32'd68256000);	// 1972-03-01
		send_seconds(32'd68169600);	// 1972-02-29
		send_seconds(32'd951782400);	// 2000-02-29
		send_seconds(32'd951868800);	// 2000-03-01
		send_seconds(32'd4107542399);	// 2100-02-28 end of day
		send_seconds(32'd4107542400);	// 2100-03-01
		send_seconds(32'd946684799);	// 1999-12-31 23:59:59
		send_seconds(32'd86399);
	endtask

	// offset extremes, including wrap below zero and above 2^32
	task automatic test_offset_extremes();
		write_offset(18'sd86400);
		send_seconds(32'hFFFF_FFFF);
		send_seconds(32'd0);
		write_offset(-18'sd86400);
		send_seconds(32'd0);
		send_seconds(32'd86399);
		send_seconds(32'hFFFF_FFFF);
		write_offset(18'h1FFFF);	// most positive pattern
		send_seconds(32'hFFFF_0000);
		write_offset(18'h20000);	// most negative pattern
		send_seconds(32'd5);
		send_seconds(32'hFFFF_FFFF);
	endtask

	task automatic test_random_dates(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				write_offset($urandom_range(1) ? 18'($signed($urandom_range(172800)) - 86400)
					: 18'($urandom));
			end
			send_seconds(rand_seconds());
		end
	endtask

	// receiver holds off long, sender keeps offering, then sender waits for drain
	task automatic test_backpressure();
		hold_reqs++;
		for (int i = 0; i < 30; i++) send_seconds(rand_seconds());
		wait_drained();
		for (int i = 0; i < 10; i++) send_seconds(rand_seconds());
	endtask

	// receiver ready, with random idling or a counted hold-off
	always @(negedge clk) begin
		if (hold_taken != hold_reqs) begin
			hold_taken = hold_reqs;
			hold_cycles = LongHold;
		end
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each result with the oldest expected date
	always @(posedge clk) begin
		cal_date_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = cal_date_t'(m_axis_tdata[40:0]);
			if (dates_due.size() == 0) begin
				$error("result with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				want = dates_due.pop_front();
				if (got.second !== want.second) begin
					$error("second_of_minute exp %0d got %0d", want.second, got.second);
					errors++;
				end
				if (got.minute !== want.minute) begin
					$error("minute_of_hour exp %0d got %0d", want.minute, got.minute);
					errors++;
				end
				if (got.hour !== want.hour) begin
					$error("hour_of_day exp %0d got %0d", want.hour, got.hour);
					errors++;
				end
				if (got.wday !== want.wday) begin
					$error("day_of_week exp %0d got %0d", want.wday, got.wday);
					errors++;
				end
				if (got.year !== want.year) begin
					$error("year_number exp %0d got %0d", want.year, got.year);
					errors++;
				end
				if (got.month !== want.month) begin
					$error("month_number exp %0d got %0d", want.month, got.month);
					errors++;
				end
				if (got.mday !== want.mday) begin
					$error("day_of_month exp %0d got %0d", want.mday, got.mday);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		send_idle_pct = 0;
		recv_idle_pct = 0;
		tz_offset = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_dates();
		test_offset_extremes();
		send_idle_pct = 30;
		recv_idle_pct = 66;
		test_random_dates(170);
		send_idle_pct = 66;
		recv_idle_pct = 30;
		test_random_dates(170);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_dates(120);
		test_backpressure();

		wait_drained();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
